[sv/circular_queue_fifo_core_defines.svh]
// ----------------------------------------------------------------------------
// Circular queue FIFO assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_FIFO_CORE_DEFINES_SVH
`define CIRCULAR_QUEUE_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CQF_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);
`define CQF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CQF_ASSERT_HOLDS(lbl, expr, msg)
`define CQF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/cqf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue FIFO package
// Sizes, action and status codes, transfer payload types and word helpers.
// ----------------------------------------------------------------------------
package cqf_pkg;

    localparam int SLOTS      = 8;
    localparam int DATA_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int CELLS      = SLOTS - 1;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_UNDERFLOW  = 2'd2,
        ST_PEEK_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [FIELD_BITS-1:0] value;
    } cqf_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] data;
        logic [1:0]            status;
        logic                  now_empty;
        logic                  now_full;
    } cqf_out_t;

    typedef struct packed {
        logic                 shift;
        logic                 load;
        logic [DATA_BITS-1:0] word;
    } cqf_cmd_t;

    function automatic logic [DATA_BITS-1:0] to_word(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS+DATA_BITS-1:0] ext;
        ext = {{DATA_BITS{1'b0}}, v};
        return ext[DATA_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] from_word(input logic [DATA_BITS-1:0] w);
        logic [FIELD_BITS+DATA_BITS-1:0] ext;
        ext = {{FIELD_BITS{1'b0}}, w};
        return ext[FIELD_BITS-1:0];
    endfunction

endpackage

[sv/cqf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue FIFO cell
// One queue position: takes its upper neighbor's word on a shift, or the
// incoming word when it is the first free position on a load.
// ----------------------------------------------------------------------------
module cqf_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cqf_pkg::cqf_cmd_t             cmd,
    input  logic                          prev_valid,
    input  logic                          next_valid,
    input  logic [cqf_pkg::DATA_BITS-1:0] next_data,
    output logic                          cell_valid,
    output logic [cqf_pkg::DATA_BITS-1:0] cell_data
);
    import cqf_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [DATA_BITS-1:0] data_reg;
    logic [DATA_BITS-1:0] data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.shift) begin
            valid_next = next_valid;
            data_next  = next_data;
        end else if (cmd.load && !valid_reg && prev_valid) begin
            valid_next = 1'b1;
            data_next  = cmd.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_valid = valid_reg;
    assign cell_data  = data_reg;

endmodule

[sv/circular_queue_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue FIFO core
// Request-driven FIFO of SLOTS-1 words: enqueue, dequeue or peek per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry one request (action, value) per transfer.
//   m_valid/m_ready/m_payload return exactly one result per request: data,
//   status, and the empty and full flags after the request took effect.
//   The result is registered: valid in the cycle after the request transfers.
//   Throughput is one request per cycle; the queue is a row of SLOTS-1 cells,
//   the oldest word in cell 0, and a dequeue shifts every cell down by one
//   in the same cycle, so no request waits on another.
//   A full enqueue, an empty dequeue or an empty peek reports its status and
//   leaves the queue unchanged; action code 3 does nothing and reports ok.
//   Reset empties the queue and drops any pending result.
//   While the receiver holds m_ready low with a result pending, s_ready is
//   low and the queue holds; a new request is taken in the cycle the pending
//   result transfers.
// ----------------------------------------------------------------------------
`include "circular_queue_fifo_core_defines.svh"

module circular_queue_fifo_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cqf_pkg::cqf_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output cqf_pkg::cqf_out_t m_payload
);
    import cqf_pkg::*;

    logic [CELLS-1:0]     valid_bits;
    logic [DATA_BITS-1:0] cell_data  [CELLS];
    logic [CELLS-1:0]     prev_valid;
    logic [CELLS-1:0]     next_valid;
    logic [DATA_BITS-1:0] next_data  [CELLS];
    cqf_cmd_t             cmd;

    logic                  in_fire;
    logic                  is_empty;
    logic                  is_full;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [FIELD_BITS-1:0] m_data_reg;
    logic [FIELD_BITS-1:0] m_data_next;
    status_t               m_status_reg;
    status_t               m_status_next;

    assign s_ready  = !m_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;
    assign is_empty = !valid_bits[0];
    assign is_full  = valid_bits[CELLS-1];

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign prev_valid[i] = 1'b1;
        end else begin : g_inner
            assign prev_valid[i] = valid_bits[i-1];
        end
        if (i == CELLS - 1) begin : g_last
            assign next_valid[i] = 1'b0;
            assign next_data[i]  = '0;
        end else begin : g_link
            assign next_valid[i] = valid_bits[i+1];
            assign next_data[i]  = cell_data[i+1];
        end

        cqf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_valid (prev_valid[i]),
            .next_valid (next_valid[i]),
            .next_data  (next_data[i]),
            .cell_valid (valid_bits[i]),
            .cell_data  (cell_data[i])
        );
    end

    always_comb begin
        cmd.shift     = 1'b0;
        cmd.load      = 1'b0;
        cmd.word      = to_word(s_payload.value);
        m_status_next = ST_OK;
        m_data_next   = '0;
        unique case (s_payload.action)
            ACT_ENQ: begin
                if (is_full) begin
                    m_status_next = ST_OVERFLOW;
                end else begin
                    cmd.load = in_fire;
                end
            end
            ACT_DEQ: begin
                if (is_empty) begin
                    m_status_next = ST_UNDERFLOW;
                end else begin
                    cmd.shift   = in_fire;
                    m_data_next = from_word(cell_data[0]);
                end
            end
            ACT_PEEK: begin
                if (is_empty) begin
                    m_status_next = ST_PEEK_EMPTY;
                end else begin
                    m_data_next = from_word(cell_data[0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_payload.data      = m_data_reg;
    assign m_payload.status    = m_status_reg;
    assign m_payload.now_empty = is_empty;
    assign m_payload.now_full  = is_full;

    `CQF_ASSERT_HOLDS(a_cells_packed, ((valid_bits >> 1) & ~valid_bits) == '0, "occupied cells not packed toward the head")
    `CQF_ASSERT_HOLDS(a_overflow_full, !(m_valid && m_status_reg == ST_OVERFLOW) || is_full, "overflow reported on a queue that is not full")
    `CQF_ASSERT_HOLDS(a_underflow_empty, !(m_valid && (m_status_reg == ST_UNDERFLOW || m_status_reg == ST_PEEK_EMPTY)) || is_empty, "empty status reported on a queue with words")
    `CQF_ASSERT_NEXT(a_deq_count, cmd.shift, $countones(valid_bits) == $past($countones(valid_bits)) - 1, "dequeue did not remove exactly one word")
    `CQF_ASSERT_NEXT(a_enq_count, cmd.load, $countones(valid_bits) == $past($countones(valid_bits)) + 1, "enqueue did not add exactly one word")

endmodule

[sim/tb_circular_queue_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue FIFO core testbench
// Drives enqueue, dequeue, peek and no-op requests through the valid/ready
// request channel and checks every result against a ring-buffer model that
// keeps one slot free. Runs a directed sequence over the empty and full edges,
// then biased random bursts under several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_circular_queue_fifo_core;

    import cqf_pkg::*;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         PHASE_ITEMS  = 190;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    class fifo_ring_model;
        logic [DATA_BITS-1:0] ring [SLOTS];
        int unsigned          head;
        int unsigned          tail;
        cqf_out_t             pending_results [$];
        int unsigned          mismatches;

        function new();
            head       = 0;
            tail       = 0;
            mismatches = 0;
        endfunction

        function void note_request(cqf_in_t req);
            cqf_out_t    r;
            int unsigned nxt;
            r = '0;
            case (req.action)
                ACT_ENQ: begin
                    nxt = (tail + 1) % SLOTS;
                    if (nxt == head) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        tail       = nxt;
                        ring[tail] = req.value[DATA_BITS-1:0];
                    end
                end
                ACT_DEQ: begin
                    if (head == tail) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        head   = (head + 1) % SLOTS;
                        r.data = ring[head];
                    end
                end
                ACT_PEEK: begin
                    if (head == tail) begin
                        r.status = ST_PEEK_EMPTY;
                    end else begin
                        r.data = ring[(head + 1) % SLOTS];
                    end
                end
                default: ;
            endcase
            r.now_empty = (head == tail);
            r.now_full  = (((tail + 1) % SLOTS) == head);
            pending_results.push_back(r);
        endfunction

        function void check_result(cqf_out_t got);
            cqf_out_t want;
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.data !== want.data) begin
                $error("data mismatch: expected %h, actual %h", want.data, got.data);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.now_empty !== want.now_empty) begin
                $error("now_empty mismatch: expected %b, actual %b",
                       want.now_empty, got.now_empty);
                mismatches++;
            end
            if (got.now_full !== want.now_full) begin
                $error("now_full mismatch: expected %b, actual %b",
                       want.now_full, got.now_full);
                mismatches++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cqf_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    cqf_out_t m_payload;

    fifo_ring_model ring_model = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_served;
    int quiet_cycles = 0;

    circular_queue_fifo_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                ring_model.note_request(s_payload);
            end
            if (m_valid && m_ready) begin
                ring_model.check_result(m_payload);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready     <= 1'b0;
        hold_served  = 0;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_payload.action <= act;
        s_payload.value  <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ring_model.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_burst(input mix_t mix, input int count);
        int          roll;
        int          pick;
        logic [1:0]  act;
        logic [31:0] val;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  act = roll < 72 ? ACT_ENQ : roll < 88 ? ACT_DEQ :
                                 roll < 97 ? ACT_PEEK : ACT_NONE;
                MIX_DRAIN: act = roll < 18 ? ACT_ENQ : roll < 82 ? ACT_DEQ :
                                 roll < 97 ? ACT_PEEK : ACT_NONE;
                default:   act = roll < 40 ? ACT_ENQ : roll < 78 ? ACT_DEQ :
                                 roll < 95 ? ACT_PEEK : ACT_NONE;
            endcase
            pick = $urandom_range(0, 15);
            val  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
            send_request(act, val);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int items);
        int sent;
        int burst;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(4, 24);
            send_random_burst(mix_t'($urandom_range(0, 2)), burst);
            sent += burst;
        end
        wait_for_results();
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_payload      <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_asked      = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue edges
        send_request(ACT_PEEK, 32'h1234_5678);
        send_request(ACT_DEQ,  32'hFFFF_FFFF);
        send_request(ACT_NONE, 32'hDEAD_BEEF);
        send_request(ACT_ENQ,  32'h0000_0000);
        send_request(ACT_ENQ,  32'hFFFF_FFFF);
        send_request(ACT_PEEK, 32'h0);
        send_request(ACT_DEQ,  32'h0);
        send_request(ACT_DEQ,  32'h0);
        send_request(ACT_DEQ,  32'h0);
        // fill to capacity, overflow, then drain
        send_request(ACT_ENQ,  32'hAAAA_5555);
        send_request(ACT_ENQ,  32'h5555_AAAA);
        send_request(ACT_ENQ,  32'h8000_0000);
        send_request(ACT_ENQ,  32'h0000_0001);
        send_request(ACT_ENQ,  32'hFFFF_FFFF);
        send_request(ACT_ENQ,  32'h0F0F_F0F0);
        send_request(ACT_ENQ,  32'h0000_0000);
        send_request(ACT_ENQ,  32'hCAFE_F00D);
        send_request(ACT_PEEK, 32'h0);
        send_request(ACT_NONE, 32'hFFFF_FFFF);
        for (int i = 0; i < CELLS; i++) begin
            send_request(ACT_DEQ, 32'h0);
        end
        wait_for_results();

        // hold off the receiver while requests keep coming
        hold_asked++;
        send_random_burst(MIX_EVEN, 24);
        wait_for_results();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(70, 0, PHASE_ITEMS);
        run_phase(0, 70, PHASE_ITEMS);
        run_phase(24, 24, PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ring_model.mismatches == 0 && ring_model.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/cqf_pkg.sv
sv/cqf_cell.sv
sv/circular_queue_fifo_core.sv
sim/tb_circular_queue_fifo_core.sv
